@@ rtl/lrc_pkg.sv @@
// ----------------------------------------------------------------------------
// lrc_pkg
// Shared types, constants and the byte-wide CRC-32 update for the log record
// checker.
// ----------------------------------------------------------------------------
package lrc_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_PAYLOAD_DEF = 1048576;
    localparam int OFFSET_BITS_DEF = 40;

    // Fixed field widths
    localparam int LEN_W    = 21;
    localparam int OFF_W    = 40;
    localparam int CNT_W    = 32;
    localparam int KIND_W   = 2;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_DATA_W = 96;

    // Record header layout
    localparam logic [3:0] HDR_MAGIC_END = 4'd4;
    localparam logic [3:0] HDR_LEN_END   = 4'd8;
    localparam logic [3:0] HDR_BYTES     = 4'd12;

    // Reflected CRC-32
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAGIC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIMIT = 2'd1;

    localparam logic [LEN_W-1:0] LIMIT_RESET = 21'd1048576;

    // Event codes on the result word
    localparam logic [KIND_W-1:0] EVT_ACCEPT = 2'd0;
    localparam logic [KIND_W-1:0] EVT_CLEAN  = 2'd1;
    localparam logic [KIND_W-1:0] EVT_TORN   = 2'd2;

    // One input word: a file byte or the end-of-file mark
    typedef struct packed {
        logic       eof;
        logic [7:0] data;
    } t_in_word;

    // One result word
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  length;
        logic [OFF_W-1:0]  offset;
        logic [CNT_W-1:0]  count;
    } t_result;

    // Fold one byte into the reflected CRC-32, one bit per step
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

@@ rtl/lrc_in_reg.sv @@
// ----------------------------------------------------------------------------
// lrc_in_reg
// Input register: holds one accepted word until the parser takes it.
// ----------------------------------------------------------------------------
module lrc_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  lrc_pkg::t_in_word i_word,
    output logic              o_valid,
    input  logic              i_ready,
    output lrc_pkg::t_in_word o_word
);

    logic              r_valid;
    lrc_pkg::t_in_word r_word;

    // Take a new word whenever the held one is empty or leaves this cycle
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Hold the payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

@@ rtl/lrc_parser.sv @@
// ----------------------------------------------------------------------------
// lrc_parser
// Header parse, payload CRC and record bookkeeping, one word per cycle while the
// result register on the output side is free or being read.
// ----------------------------------------------------------------------------
module lrc_parser #(
    parameter int MAX_PAYLOAD = lrc_pkg::MAX_PAYLOAD_DEF,
    parameter int OFFSET_BITS = lrc_pkg::OFFSET_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [31:0]                 i_magic,
    input  logic [lrc_pkg::LEN_W-1:0]   i_limit,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  lrc_pkg::t_in_word           i_word,
    output logic                        o_valid,
    input  logic                        i_ready,
    output lrc_pkg::t_result            o_result
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_HALTED
    } t_phase;

    localparam logic [31:0] MaxLen = 32'(MAX_PAYLOAD);

    t_phase                    r_phase, n_phase;
    logic [3:0]                r_hdr_cnt, n_hdr_cnt;
    logic [31:0]               r_hdr_word, n_hdr_word;
    logic [lrc_pkg::LEN_W-1:0] r_len, n_len;
    logic [31:0]               r_crc_exp, n_crc_exp;
    logic [lrc_pkg::LEN_W-1:0] r_left, n_left;
    logic [31:0]               r_crc, n_crc;
    logic [31:0]               r_count, n_count;
    logic [OFFSET_BITS-1:0]    r_start, n_start;
    logic                      r_out_valid;
    lrc_pkg::t_result          r_out;

    logic                      w_advance;
    logic                      w_emit;
    lrc_pkg::t_result          w_res;
    logic [31:0]               w_hdr_next;
    logic [3:0]                w_cnt_next;
    logic [31:0]               w_crc_upd;
    logic [lrc_pkg::LEN_W-1:0] w_left_dec;
    logic [31:0]               w_limit;
    logic                      w_finish;
    logic [31:0]               w_fin_crc;
    logic [31:0]               w_fin_exp;
    logic [63:0]               w_start_wide;

    // Move a word only when the result register can take a result
    assign o_ready   = !r_out_valid || i_ready;
    assign w_advance = i_valid && o_ready;

    assign w_hdr_next   = {r_hdr_word[23:0], i_word.data};
    assign w_cnt_next   = r_hdr_cnt + 4'd1;
    assign w_crc_upd    = lrc_pkg::crc_byte(r_crc, i_word.data);
    assign w_left_dec   = r_left - lrc_pkg::LEN_W'(1);
    assign w_limit      = ({11'd0, i_limit} < MaxLen) ? {11'd0, i_limit} : MaxLen;
    assign w_start_wide = 64'(r_start);

    // Next state and result for the word at the input
    always_comb begin
        n_phase    = r_phase;
        n_hdr_cnt  = r_hdr_cnt;
        n_hdr_word = r_hdr_word;
        n_len      = r_len;
        n_crc_exp  = r_crc_exp;
        n_left     = r_left;
        n_crc      = r_crc;
        n_count    = r_count;
        n_start    = r_start;
        w_emit     = 1'b0;
        w_finish   = 1'b0;
        w_fin_crc  = 32'd0;
        w_fin_exp  = r_crc_exp;
        w_res.kind   = lrc_pkg::EVT_TORN;
        w_res.length = '0;
        w_res.offset = w_start_wide[lrc_pkg::OFF_W-1:0];
        w_res.count  = r_count;

        if (i_word.eof) begin
            // End of file: report unless halted, then return to the reset state
            if (r_phase == PH_HEADER && r_hdr_cnt == 4'd0) begin
                w_emit     = 1'b1;
                w_res.kind = lrc_pkg::EVT_CLEAN;
            end else if (r_phase != PH_HALTED) begin
                w_emit = 1'b1;
            end
            n_phase    = PH_HEADER;
            n_hdr_cnt  = 4'd0;
            n_hdr_word = 32'd0;
            n_len      = '0;
            n_crc_exp  = 32'd0;
            n_left     = '0;
            n_crc      = lrc_pkg::CRC_INIT;
            n_count    = 32'd0;
            n_start    = '0;
        end else begin
            case (r_phase)
                PH_PAYLOAD: begin
                    n_crc  = w_crc_upd;
                    n_left = w_left_dec;
                    if (w_left_dec == '0) begin
                        w_finish  = 1'b1;
                        w_fin_crc = ~w_crc_upd;
                    end
                end
                PH_HEADER: begin
                    n_hdr_word = w_hdr_next;
                    n_hdr_cnt  = w_cnt_next;
                    if (w_cnt_next == lrc_pkg::HDR_MAGIC_END) begin
                        if (w_hdr_next != i_magic) begin
                            w_emit  = 1'b1;
                            n_phase = PH_HALTED;
                        end
                    end else if (w_cnt_next == lrc_pkg::HDR_LEN_END) begin
                        n_len = w_hdr_next[lrc_pkg::LEN_W-1:0];
                        if (w_hdr_next > w_limit) begin
                            w_emit  = 1'b1;
                            n_phase = PH_HALTED;
                        end
                    end else if (w_cnt_next == lrc_pkg::HDR_BYTES) begin
                        n_crc_exp  = w_hdr_next;
                        n_hdr_cnt  = 4'd0;
                        n_hdr_word = 32'd0;
                        if (r_len == '0) begin
                            // Empty payload: its CRC must read zero
                            w_finish  = 1'b1;
                            w_fin_crc = 32'd0;
                            w_fin_exp = w_hdr_next;
                        end else begin
                            n_phase = PH_PAYLOAD;
                            n_left  = r_len;
                            n_crc   = lrc_pkg::CRC_INIT;
                        end
                    end
                end
                default: begin
                    // Halted: drop data until end of file
                end
            endcase

            // Close the record: accept it or report it torn
            if (w_finish) begin
                w_emit = 1'b1;
                if (w_fin_crc != w_fin_exp) begin
                    n_phase = PH_HALTED;
                end else begin
                    if (r_count != 32'hFFFF_FFFF) begin
                        n_count = r_count + 32'd1;
                    end
                    n_start      = r_start + OFFSET_BITS'(lrc_pkg::HDR_BYTES)
                                   + OFFSET_BITS'(r_len);
                    n_phase      = PH_HEADER;
                    n_hdr_cnt    = 4'd0;
                    n_hdr_word   = 32'd0;
                    n_crc        = lrc_pkg::CRC_INIT;
                    w_res.kind   = lrc_pkg::EVT_ACCEPT;
                    w_res.length = r_len;
                    w_res.count  = n_count;
                end
            end
        end
    end

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_hdr_cnt  <= 4'd0;
            r_hdr_word <= 32'd0;
            r_len      <= '0;
            r_crc_exp  <= 32'd0;
            r_left     <= '0;
            r_crc      <= lrc_pkg::CRC_INIT;
            r_count    <= 32'd0;
            r_start    <= '0;
        end else if (w_advance) begin
            r_phase    <= n_phase;
            r_hdr_cnt  <= n_hdr_cnt;
            r_hdr_word <= n_hdr_word;
            r_len      <= n_len;
            r_crc_exp  <= n_crc_exp;
            r_left     <= n_left;
            r_crc      <= n_crc;
            r_count    <= n_count;
            r_start    <= n_start;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTHESIS
    // Header byte count stays inside one header
    a_hdr_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_cnt < lrc_pkg::HDR_BYTES)
        else $error("header byte count out of range");

    // Payload phase always has bytes left and no partial header
    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_left != '0 && r_hdr_cnt == 4'd0))
        else $error("payload phase with nothing left");

    // An accepted record restarts header parsing with a fresh CRC
    a_accept_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_emit && w_res.kind == lrc_pkg::EVT_ACCEPT)
        |=> (r_phase == PH_HEADER && r_hdr_cnt == 4'd0 && r_crc == lrc_pkg::CRC_INIT))
        else $error("no restart after accepted record");

    // Halted state never produces a result for data
    a_halted_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_phase == PH_HALTED && !i_word.eof) |=> !$rose(r_out_valid))
        else $error("result while halted");
`endif

endmodule

@@ rtl/log_record_checker.sv @@
// ----------------------------------------------------------------------------
// log_record_checker
// Validates a length-prefixed, CRC-32 protected log stream byte by byte.
// ----------------------------------------------------------------------------
// One byte (or the end-of-file mark, tlast) is taken every cycle while the
// result stream is not holding the parser back; the rate rests on the 8-bit
// CRC-32 update and the header/offset counters in the parser. A result passes
// through the input register, then the result register. Each record is a
// 12-byte big-endian header (magic, length, CRC-32) and its payload; every
// good record reports kind 0 with its start offset and length, the first bad
// record reports kind 2 (torn) and the rest of the file is dropped, and end
// of file reports kind 1 (clean), kind 2 if a record was cut short, or
// nothing after a torn record. The end-of-file word resets all parse state;
// configuration is kept. There is no clearing pass after reset.
module log_record_checker #(
    parameter int MAX_PAYLOAD = lrc_pkg::MAX_PAYLOAD_DEF,
    parameter int OFFSET_BITS = lrc_pkg::OFFSET_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration writes
    input  logic                              i_cfg_we,
    input  logic [lrc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lrc_pkg::CFG_W-1:0]         i_cfg_wdata,
    // Input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [7:0]                        i_s_tdata,  // [7:0] data_byte
    input  logic                              i_s_tlast,  // end_of_file
    // Result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [20:0] record_length, [60:21] record_offset, [92:61] record_count
    output logic [lrc_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic [lrc_pkg::KIND_W-1:0]        o_m_tuser   // [1:0] event_kind
);

    logic [31:0]               r_record_magic;
    logic [lrc_pkg::LEN_W-1:0] r_payload_limit;

    lrc_pkg::t_in_word w_s_word;
    lrc_pkg::t_in_word w_p_word;
    logic              w_p_valid;
    logic              w_p_ready;
    lrc_pkg::t_result  w_result;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_magic  <= 32'd0;
            r_payload_limit <= lrc_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lrc_pkg::CFG_IDX_MAGIC: r_record_magic  <= i_cfg_wdata;
                lrc_pkg::CFG_IDX_LIMIT: r_payload_limit <= i_cfg_wdata[lrc_pkg::LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_s_word.eof  = i_s_tlast;
    assign w_s_word.data = i_s_tdata;

    lrc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_word  (w_s_word),
        .o_valid (w_p_valid),
        .i_ready (w_p_ready),
        .o_word  (w_p_word)
    );

    lrc_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_magic  (r_record_magic),
        .i_limit  (r_payload_limit),
        .i_valid  (w_p_valid),
        .o_ready  (w_p_ready),
        .i_word   (w_p_word),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (w_result)
    );

    // Pack the result word
    assign o_m_tdata = {3'd0, w_result.count, w_result.offset, w_result.length};
    assign o_m_tuser = w_result.kind;

endmodule
